[rtl/flb_pkg.sv]
// Package: constants, status codes and field widths for the flowlet load balancer.
package flb_pkg;

    localparam int ROUTE_ENTRIES_DEF = 16;
    localparam int FLOW_ENTRIES_DEF  = 4096;
    localparam int PORT_COUNT_DEF    = 256;

    localparam logic [31:0] TIMEOUT_RESET = 32'd50000;

    typedef enum logic [2:0] {
        ST_HIT         = 3'd0,
        ST_NEW         = 3'd1,
        ST_NOT_UNICAST = 3'd2,
        ST_NO_FWD      = 3'd3,
        ST_NO_FLOW     = 3'd4,
        ST_NO_ROUTE    = 3'd5,
        ST_ADDED       = 3'd6,
        ST_FULL        = 3'd7
    } status_t;

    localparam int IN_DATA_W  = 168;
    localparam int OUT_DATA_W = 16;

endpackage

[rtl/flb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module flb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/flowlet_load_balancer_unit.sv]
// Top level: route list, flowlet table and request sequencer.
//
//  channel   | direction | signals                          | contents
//  s_axis    | in        | tvalid tready tdata[167:0] tuser | one request
//  m_axis    | out       | tvalid tready tdata[15:0]        | status, out_port
//  cfg       | in        | cfg_wr_en cfg_wr_data[31:0]      | flowlet_timeout
//
// An add-route request, or a packet rejected on acceptance (not unicast, no forwarding,
// no flow tag), gives its result the cycle after acceptance. A packet goes through a
// count pass over the stored routes, 16 remainder steps, a pick pass, a flowlet read and
// a write-back. After reset the flowlet RAM is cleared, one entry a cycle, during which
// no request is taken. A held result stalls the input.
module flowlet_load_balancer_unit
    import flb_pkg::*;
#(
    parameter int ROUTE_ENTRIES = ROUTE_ENTRIES_DEF,
    parameter int FLOW_ENTRIES  = FLOW_ENTRIES_DEF,
    parameter int PORT_COUNT    = PORT_COUNT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [31:0]           cfg_wr_data,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // dest_addr, flow_id, flow_tag_present, forwarding_enabled, now_time,
    // random_value, route_network, route_mask, route_port (lowest first)
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // kind
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status, out_port, 5 bits zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int RA = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int RC = $clog2(ROUTE_ENTRIES + 1);
    localparam int FA = $clog2(FLOW_ENTRIES);
    localparam int RD = (ROUTE_ENTRIES > 1) ? ROUTE_ENTRIES : 2;
    localparam int PORT_RECIP = (65536 + PORT_COUNT - 1) / PORT_COUNT;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CNT, S_DIV, S_PICK, S_FLOW, S_DONE, S_OUT
    } state_t;

    state_t state_reg;
    logic [31:0] timeout_reg;
    logic [31:0] dest_reg, now_reg;
    logic [FA-1:0] slot_reg;
    logic [15:0] rnd_reg;
    logic [RC-1:0] count_reg, idx_reg, match_reg, seen_reg;
    logic [RC:0] rem_reg;
    logic [4:0] step_reg;
    logic [7:0] pick_port_reg;
    logic [2:0] status_reg;
    logic [7:0] port_reg;
    logic [FA:0] clr_reg;
    logic rd_wait_reg;

    // route RAM: network, mask, port
    logic rt_we;
    logic [RA-1:0] rt_waddr, rt_raddr;
    logic [71:0] rt_wdata, rt_rdata;
    // flowlet RAM: valid, port, time
    logic fl_we;
    logic [FA-1:0] fl_waddr, fl_raddr;
    logic [40:0] fl_wdata, fl_rdata;

    flb_ram #(.WIDTH(72), .DEPTH(RD)) u_route_ram (
        .clk(clk), .wr_en(rt_we), .wr_addr(rt_waddr), .wr_data(rt_wdata),
        .rd_addr(rt_raddr), .rd_data(rt_rdata));

    flb_ram #(.WIDTH(41), .DEPTH(FLOW_ENTRIES)) u_flow_ram (
        .clk(clk), .wr_en(fl_we), .wr_addr(fl_waddr), .wr_data(fl_wdata),
        .rd_addr(fl_raddr), .rd_data(fl_rdata));

    logic [31:0] in_dest, in_now, in_net, in_mask;
    logic [11:0] in_fid;
    logic in_tag, in_fwd;
    logic [15:0] in_rnd;
    logic [7:0] in_port;
    assign in_dest = s_axis_tdata[31:0];
    assign in_fid  = s_axis_tdata[43:32];
    assign in_tag  = s_axis_tdata[44];
    assign in_fwd  = s_axis_tdata[45];
    assign in_now  = s_axis_tdata[77:46];
    assign in_rnd  = s_axis_tdata[93:78];
    assign in_net  = s_axis_tdata[125:94];
    assign in_mask = s_axis_tdata[157:126];
    assign in_port = s_axis_tdata[165:158];

    logic accept;
    assign s_axis_tready = (state_reg == S_IDLE) && !m_axis_tvalid;
    assign accept = s_axis_tvalid && s_axis_tready;
    logic out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {5'd0, port_reg, status_reg};

    logic hit;
    assign hit = ((dest_reg ^ rt_rdata[31:0]) & rt_rdata[63:32]) == 32'd0;

    logic [RC:0] rem_sh;
    assign rem_sh = {rem_reg[RC-1:0], rnd_reg[15]};

    logic [FA-1:0] slot_in;
    assign slot_in = FA'(32'(in_fid));

    // reduce the port modulo PORT_COUNT by reciprocal multiplication
    logic [23:0] port_prod;
    logic [15:0] port_sub;
    logic [7:0] port_in;
    assign port_prod = 24'(in_port) * 24'(PORT_RECIP);
    assign port_sub = 16'(port_prod[23:16]) * 16'(PORT_COUNT);
    assign port_in = in_port - port_sub[7:0];

    logic [31:0] gap;
    assign gap = now_reg - fl_rdata[31:0];

    always_comb
    begin
        rt_we = accept && !s_axis_tuser && (count_reg < RC'(ROUTE_ENTRIES));
        rt_waddr = count_reg[RA-1:0];
        rt_wdata = {port_in, in_mask, in_net};
        rt_raddr = idx_reg[RA-1:0];
        fl_raddr = slot_reg;
        fl_we = 1'b0;
        fl_waddr = slot_reg;
        fl_wdata = {1'b1, port_reg, now_reg};
        if (state_reg == S_CLEAR)
        begin
            fl_we = 1'b1;
            fl_waddr = clr_reg[FA-1:0];
            fl_wdata = 41'd0;
        end
        else if (state_reg == S_DONE)
        begin
            fl_we = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            timeout_reg <= TIMEOUT_RESET;
            count_reg <= '0;
            clr_reg <= '0;
            out_valid_reg <= 1'b0;
            rd_wait_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (FA+1)'(FLOW_ENTRIES - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        dest_reg <= in_dest;
                        now_reg <= in_now;
                        rnd_reg <= in_rnd;
                        slot_reg <= slot_in;
                        idx_reg <= '0;
                        match_reg <= '0;
                        rd_wait_reg <= 1'b1;
                        port_reg <= 8'd0;
                        if (!s_axis_tuser)
                        begin
                            if (count_reg < RC'(ROUTE_ENTRIES))
                            begin
                                count_reg <= count_reg + 1'b1;
                                status_reg <= ST_ADDED;
                            end
                            else
                            begin
                                status_reg <= ST_FULL;
                            end
                            out_valid_reg <= 1'b1;
                        end
                        else if (in_dest[31:28] == 4'hE || in_dest == 32'hFFFF_FFFF)
                        begin
                            status_reg <= ST_NOT_UNICAST;
                            out_valid_reg <= 1'b1;
                        end
                        else if (!in_fwd)
                        begin
                            status_reg <= ST_NO_FWD;
                            out_valid_reg <= 1'b1;
                        end
                        else if (!in_tag)
                        begin
                            status_reg <= ST_NO_FLOW;
                            out_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            idx_reg <= '0;
                            state_reg <= S_CNT;
                        end
                    end
                end
                S_CNT:
                begin
                    // data arrives the cycle after the address; the next address is set only once an entry is compared
                    if (rd_wait_reg)
                    begin
                        rd_wait_reg <= 1'b0;
                        if (count_reg == '0)
                        begin
                            status_reg <= ST_NO_ROUTE;
                            out_valid_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        if (hit)
                        begin
                            match_reg <= match_reg + 1'b1;
                        end
                        if (idx_reg + 1'b1 == count_reg)
                        begin
                            if (!hit && match_reg == '0)
                            begin
                                status_reg <= ST_NO_ROUTE;
                                out_valid_reg <= 1'b1;
                                state_reg <= S_IDLE;
                            end
                            else
                            begin
                                rem_reg <= '0;
                                step_reg <= '0;
                                state_reg <= S_DIV;
                            end
                        end
                        else
                        begin
                            idx_reg <= idx_reg + 1'b1;
                            rd_wait_reg <= 1'b1;
                        end
                    end
                end
                S_DIV:
                begin
                    if (rem_sh >= {1'b0, match_reg})
                    begin
                        rem_reg <= rem_sh - {1'b0, match_reg};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                    end
                    rnd_reg <= {rnd_reg[14:0], 1'b0};
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 5'd15)
                    begin
                        idx_reg <= '0;
                        seen_reg <= '0;
                        rd_wait_reg <= 1'b1;
                        state_reg <= S_PICK;
                    end
                end
                S_PICK:
                begin
                    if (rd_wait_reg)
                    begin
                        rd_wait_reg <= 1'b0;
                    end
                    else if (hit && seen_reg == rem_reg[RC-1:0])
                    begin
                        pick_port_reg <= rt_rdata[71:64];
                        rd_wait_reg <= 1'b1;
                        state_reg <= S_FLOW;
                    end
                    else
                    begin
                        if (hit)
                        begin
                            seen_reg <= seen_reg + 1'b1;
                        end
                        idx_reg <= idx_reg + 1'b1;
                        rd_wait_reg <= 1'b1;
                    end
                end
                S_FLOW:
                begin
                    if (rd_wait_reg)
                    begin
                        rd_wait_reg <= 1'b0;
                    end
                    else
                    begin
                        if (fl_rdata[40] && gap <= timeout_reg)
                        begin
                            port_reg <= fl_rdata[39:32];
                            status_reg <= ST_HIT;
                        end
                        else
                        begin
                            port_reg <= pick_port_reg;
                            status_reg <= ST_NEW;
                        end
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/flb_checker.sv]
// Port checker for the flowlet load balancer, bound to the top level.
module flb_checker
    import flb_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("request taken while result pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] != ST_HIT && m_axis_tdata[2:0] != ST_NEW
        |-> m_axis_tdata[10:3] == 8'd0)
        else $error("port set on rejected request");

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("two requests in consecutive cycles");

endmodule

bind flowlet_load_balancer_unit flb_checker u_flb_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
